// ----- hdl/prc_pkg.sv -----
// Shared constants, types and the arctangent table of the point rotation block.
package prc_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // Rotator datapath width; the guard shift is GUARD_BASE - COORD_WIDTH,
   // which leaves three bits of headroom above the shifted difference.
   localparam int DATA_WIDTH      = 64;
   localparam int GUARD_BASE      = 60;
   localparam int TURN_WIDTH      = 32;
   localparam int ANGLE_ACC_WIDTH = 34;
   localparam int GAIN_SHIFT      = 30;
   localparam logic [GAIN_SHIFT-1:0] GAIN_Q30 = 30'd652032874;

   localparam int PREP_STAGES  = 2;
   localparam int SCALE_STAGES = 4;

   typedef enum logic [1:0] {
      CSR_CENTER_X   = 2'd0,
      CSR_CENTER_Y   = 2'd1,
      CSR_TURN_ANGLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
   localparam logic [TURN_WIDTH-1:0] ATAN_TURN [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

// ----- hdl/prc_prep.sv -----
// Front end: offset from the center, quadrant fold and guard shift.
module prc_prep #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = prc_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [prc_pkg::PREP_STAGES-1:0]             advance,
   input  prc_pkg::tag_type                            in_tag,
   input  logic signed [COORD_WIDTH-1:0]               point_x,
   input  logic signed [COORD_WIDTH-1:0]               point_y,
   input  logic signed [COORD_WIDTH-1:0]               center_x,
   input  logic signed [COORD_WIDTH-1:0]               center_y,
   input  logic [ANGLE_WIDTH-1:0]                      angle,
   output logic [prc_pkg::PREP_STAGES-1:0]             stage_valid,
   output prc_pkg::tag_type                            out_tag,
   output logic signed [prc_pkg::DATA_WIDTH-1:0]       out_x,
   output logic signed [prc_pkg::DATA_WIDTH-1:0]       out_y,
   output logic signed [prc_pkg::ANGLE_ACC_WIDTH-1:0]  out_z
);

   localparam int DW    = prc_pkg::DATA_WIDTH;
   localparam int ZW    = prc_pkg::ANGLE_ACC_WIDTH;
   localparam int TW    = prc_pkg::TURN_WIDTH;
   localparam int GUARD = prc_pkg::GUARD_BASE - COORD_WIDTH;
   localparam int EXT   = DW - COORD_WIDTH - 1 - GUARD;

   prc_pkg::tag_type            tag1_ff, tag2_ff;
   logic [COORD_WIDTH:0]        dx_in, dy_in, dx_ff, dy_ff;
   logic [TW-1:0]               turn;
   logic                        fold;
   logic signed [DW-1:0]        xs, ys, x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0]        z_in, z_ff;

   assign dx_in = {point_x[COORD_WIDTH-1], point_x} - {center_x[COORD_WIDTH-1], center_x};
   assign dy_in = {point_y[COORD_WIDTH-1], point_y} - {center_y[COORD_WIDTH-1], center_y};

   // Angles in the left half plane are turned by a half turn first, which
   // keeps the residual angle inside the converging range of the rotator.
   always_comb begin
      turn = {angle, {(TW-ANGLE_WIDTH){1'b0}}};
      fold = turn[TW-1] ^ turn[TW-2];
      xs   = {{EXT{dx_ff[COORD_WIDTH]}}, dx_ff, {GUARD{1'b0}}};
      ys   = {{EXT{dy_ff[COORD_WIDTH]}}, dy_ff, {GUARD{1'b0}}};
      x_in = fold ? -xs : xs;
      y_in = fold ? -ys : ys;
      z_in = {{(ZW-TW+1){turn[TW-1] ^ fold}}, turn[TW-2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else begin
         if (advance[0]) tag1_ff.valid <= in_tag.valid;
         if (advance[1]) tag2_ff.valid <= tag1_ff.valid;
      end
      if (advance[0]) begin
         tag1_ff.last <= in_tag.last;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
      end
      if (advance[1]) begin
         tag2_ff.last <= tag1_ff.last;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
      end
   end

   assign stage_valid = {tag2_ff.valid, tag1_ff.valid};
   assign out_tag     = tag2_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_z       = z_ff;

endmodule

// ----- hdl/prc_cordic_stage.sv -----
// One registered micro-rotation of the CORDIC rotator.
module prc_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  prc_pkg::tag_type                            in_tag,
   input  logic signed [prc_pkg::DATA_WIDTH-1:0]       in_x,
   input  logic signed [prc_pkg::DATA_WIDTH-1:0]       in_y,
   input  logic signed [prc_pkg::ANGLE_ACC_WIDTH-1:0]  in_z,
   output prc_pkg::tag_type                            out_tag,
   output logic signed [prc_pkg::DATA_WIDTH-1:0]       out_x,
   output logic signed [prc_pkg::DATA_WIDTH-1:0]       out_y,
   output logic signed [prc_pkg::ANGLE_ACC_WIDTH-1:0]  out_z
);

   localparam int DW = prc_pkg::DATA_WIDTH;
   localparam int ZW = prc_pkg::ANGLE_ACC_WIDTH;
   localparam logic signed [ZW-1:0] STEP =
      {{(ZW-prc_pkg::TURN_WIDTH){1'b0}}, prc_pkg::ATAN_TURN[SHIFT]};

   prc_pkg::tag_type      tag_ff;
   logic signed [DW-1:0]  x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0]  z_in, z_ff;

   always_comb begin
      if (!in_z[ZW-1]) begin
         x_in = in_x - (in_y >>> SHIFT);
         y_in = in_y + (in_x >>> SHIFT);
         z_in = in_z - STEP;
      end else begin
         x_in = in_x + (in_y >>> SHIFT);
         y_in = in_y - (in_x >>> SHIFT);
         z_in = in_z + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_ff.valid <= in_tag.valid;
      end
      if (advance) begin
         tag_ff.last <= in_tag.last;
         x_ff        <= x_in;
         y_ff        <= y_in;
         z_ff        <= z_in;
      end
   end

   assign out_tag = tag_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

// ----- hdl/prc_scale.sv -----
// Back end: gain compensation, rounding, center offset and saturation.
module prc_scale #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [prc_pkg::SCALE_STAGES-1:0]       advance,
   input  prc_pkg::tag_type                       in_tag,
   input  logic signed [prc_pkg::DATA_WIDTH-1:0]  in_x,
   input  logic signed [prc_pkg::DATA_WIDTH-1:0]  in_y,
   input  logic signed [COORD_WIDTH-1:0]          center_x,
   input  logic signed [COORD_WIDTH-1:0]          center_y,
   output logic [prc_pkg::SCALE_STAGES-1:0]       stage_valid,
   output prc_pkg::tag_type                       out_tag,
   output logic signed [COORD_WIDTH-1:0]          out_x,
   output logic signed [COORD_WIDTH-1:0]          out_y
);

   localparam int DW    = prc_pkg::DATA_WIDTH;
   localparam int KS    = prc_pkg::GAIN_SHIFT;
   localparam int GUARD = prc_pkg::GUARD_BASE - COORD_WIDTH;
   localparam int WW    = DW + 2;
   localparam int TW    = COORD_WIDTH + 3;
   localparam int RW    = TW + 1;
   localparam int NS    = prc_pkg::SCALE_STAGES;
   localparam logic signed [WW-1:0] HALF = WW'(1) <<< (GUARD - 1);
   localparam logic signed [KS:0]   GAIN = {1'b0, prc_pkg::GAIN_Q30};

   prc_pkg::tag_type tag_ff [NS];

   logic signed [DW-1:0]          v      [2];
   logic signed [COORD_WIDTH-1:0] center [2];
   logic signed [DW:0]            phi_in [2];
   logic signed [DW:0]            phi_ff [2];
   logic [2*KS-1:0]               plo    [2];
   logic [KS-1:0]                 plo_ff [2];
   logic signed [WW-1:0]          w_in   [2];
   logic signed [WW-1:0]          w_ff   [2];
   logic signed [WW-1:0]          rnd    [2];
   logic signed [TW-1:0]          t_ff   [2];
   logic signed [RW-1:0]          r      [2];
   logic [RW-COORD_WIDTH:0]       top    [2];
   logic signed [COORD_WIDTH-1:0] sat_in [2];
   logic signed [COORD_WIDTH-1:0] sat_ff [2];

   assign v[0]      = in_x;
   assign v[1]      = in_y;
   assign center[0] = center_x;
   assign center[1] = center_y;

   // The gain product is split at bit 30: a signed high part and an unsigned
   // low part, whose product only contributes its upper half.
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         phi_in[a] = (DW+1)'($signed(v[a][DW-1:KS])) * (DW+1)'(GAIN);
         plo[a]    = (2*KS)'(v[a][KS-1:0]) * (2*KS)'(prc_pkg::GAIN_Q30);
         w_in[a]   = {phi_ff[a][DW], phi_ff[a]} + $signed({{(WW-KS){1'b0}}, plo_ff[a]});
         rnd[a]    = w_ff[a] + HALF;
         r[a]      = {t_ff[a][TW-1], t_ff[a]}
                   + {{(RW-COORD_WIDTH){center[a][COORD_WIDTH-1]}}, center[a]};
         top[a]    = r[a][RW-1:COORD_WIDTH-1];
         if ((&top[a]) || !(|top[a])) begin
            sat_in[a] = r[a][COORD_WIDTH-1:0];
         end else if (r[a][RW-1]) begin
            sat_in[a] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            sat_in[a] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) tag_ff[s].valid <= 1'b0;
      end else begin
         if (advance[0]) tag_ff[0].valid <= in_tag.valid;
         for (int s = 1; s < NS; s++) begin
            if (advance[s]) tag_ff[s].valid <= tag_ff[s-1].valid;
         end
      end
      if (advance[0]) tag_ff[0].last <= in_tag.last;
      for (int s = 1; s < NS; s++) begin
         if (advance[s]) tag_ff[s].last <= tag_ff[s-1].last;
      end
      for (int a = 0; a < 2; a++) begin
         if (advance[0]) begin
            phi_ff[a] <= phi_in[a];
            plo_ff[a] <= plo[a][2*KS-1:KS];
         end
         if (advance[1]) w_ff[a]   <= w_in[a];
         if (advance[2]) t_ff[a]   <= rnd[a][GUARD+TW-1:GUARD];
         if (advance[3]) sat_ff[a] <= sat_in[a];
      end
   end

   always_comb begin
      for (int s = 0; s < NS; s++) stage_valid[s] = tag_ff[s].valid;
   end

   assign out_tag = tag_ff[NS-1];
   assign out_x   = sat_ff[0];
   assign out_y   = sat_ff[1];

endmodule

// ----- hdl/point_rotation_about_center_core.sv -----
// Top level of the point rotation block: registers, pipeline and flow control.
//
// Rotates a stream of signed fixed-point points about a programmable center
// by a programmable angle (2^ANGLE_WIDTH units per turn, counterclockwise).
// Input items enter on req_valid while req_stall is low; results leave on
// rsp_valid and are taken when rsp_stall is low. The last flag of each item
// travels with it unchanged. Results saturate to the coordinate range.
// The csr port writes center_x (index 0), center_y (index 1) and turn_angle
// (index 2); other indexes are ignored. csr_ready is always high, and the
// registers must only be written while no item is in flight.
// The pipeline has two front-end stages, one stage per CORDIC micro-rotation
// and four stages for the gain multiply, rounding, center offset and
// saturation. One item is accepted every cycle while req_stall is low.
// Every stage holds a valid bit. A stage loads when it is empty or the stage
// after it loads, so a stalled output lets empty stages fill, and req_stall
// rises only when every stage holds an item. Reset empties the pipeline and
// clears the registers to zero.
module point_rotation_about_center_core #(
   parameter int COORD_WIDTH   = prc_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = prc_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = prc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  logic                                  req_last_point_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_WIDTH-1:0]         rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_rotated_y,
   output logic                                  rsp_last_point_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_data
);

   localparam int DW = prc_pkg::DATA_WIDTH;
   localparam int ZW = prc_pkg::ANGLE_ACC_WIDTH;
   localparam int NP = prc_pkg::PREP_STAGES;
   localparam int NC = CORDIC_STAGES;
   localparam int NQ = prc_pkg::SCALE_STAGES;
   localparam int NS = NP + NC + NQ;

   logic signed [COORD_WIDTH-1:0] center_x_ff, center_y_ff;
   logic [ANGLE_WIDTH-1:0]        angle_ff;

   logic [NS-1:0] vld;
   logic [NS:0]   rdy;

   prc_pkg::tag_type     in_tag, out_tag;
   prc_pkg::tag_type     c_tag [NC+1];
   logic signed [DW-1:0] c_x   [NC+1];
   logic signed [DW-1:0] c_y   [NC+1];
   logic signed [ZW-1:0] c_z   [NC+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         angle_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            prc_pkg::CSR_CENTER_X:   center_x_ff <= csr_data[COORD_WIDTH-1:0];
            prc_pkg::CSR_CENTER_Y:   center_y_ff <= csr_data[COORD_WIDTH-1:0];
            prc_pkg::CSR_TURN_ANGLE: angle_ff    <= csr_data[ANGLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Stage k loads when it is empty or stage k+1 loads.
   assign rdy[NS] = !rsp_stall;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_ready
         assign rdy[k] = !vld[k] || rdy[k+1];
      end
   endgenerate

   assign req_stall    = !rdy[0];
   assign in_tag.valid = req_valid;
   assign in_tag.last  = req_last_point_in;

   prc_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (rdy[NP-1:0]),
      .in_tag      (in_tag),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .angle       (angle_ff),
      .stage_valid (vld[NP-1:0]),
      .out_tag     (c_tag[0]),
      .out_x       (c_x[0]),
      .out_y       (c_y[0]),
      .out_z       (c_z[0])
   );

   generate
      for (k = 0; k < NC; k++) begin : g_cordic
         prc_cordic_stage #(
            .SHIFT (k)
         ) u_stage (
            .clock   (clock),
            .reset   (reset),
            .advance (rdy[NP+k]),
            .in_tag  (c_tag[k]),
            .in_x    (c_x[k]),
            .in_y    (c_y[k]),
            .in_z    (c_z[k]),
            .out_tag (c_tag[k+1]),
            .out_x   (c_x[k+1]),
            .out_y   (c_y[k+1]),
            .out_z   (c_z[k+1])
         );
         assign vld[NP+k] = c_tag[k+1].valid;
      end
   endgenerate

   prc_scale #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .advance     (rdy[NS-1:NP+NC]),
      .in_tag      (c_tag[NC]),
      .in_x        (c_x[NC]),
      .in_y        (c_y[NC]),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .stage_valid (vld[NS-1:NP+NC]),
      .out_tag     (out_tag),
      .out_x       (rsp_rotated_x),
      .out_y       (rsp_rotated_y)
   );

   assign rsp_valid          = out_tag.valid;
   assign rsp_last_point_out = out_tag.last;

endmodule
